// File: hw/rtl/bcdr_pkg.sv
// Package with shared constants and types for the button click detector.
`default_nettype none
package bcdr_pkg;

    localparam int NUM_BUTTONS = 32;
    localparam int TIME_W = 32;

    // Register indexes on the configuration port.
    localparam logic REG_REPEAT = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [31:0] REPEAT_RESET = 32'd500000;
    localparam logic [31:0] WINDOW_RESET = 32'd300000;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DOWN1 = 3'd1,
        PH_UP1   = 3'd2,
        PH_DOWN2 = 3'd3,
        PH_HELD  = 3'd4
    } t_phase;

    typedef struct packed {
        logic click;
        logic dbl;
    } t_lane_evt;

endpackage
`default_nettype wire

// File: hw/rtl/bcdr_lane.sv
// One button lane: phase machine and last action time for a single button.
`default_nettype none
module bcdr_lane (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_pressed,
    input  wire [bcdr_pkg::TIME_W-1:0]     i_now,
    input  wire [bcdr_pkg::TIME_W-1:0]     i_repeat,
    input  wire [bcdr_pkg::TIME_W-1:0]     i_window,
    output bcdr_pkg::t_lane_evt            o_evt
);

    bcdr_pkg::t_phase r_phase;
    bcdr_pkg::t_phase n_phase;
    logic [bcdr_pkg::TIME_W-1:0] r_last;
    logic [bcdr_pkg::TIME_W-1:0] dt;
    logic rep_over;
    logic win_below;
    logic win_over;
    logic record;

    // Differences wrap modulo the time width, so a time that goes backwards
    // reads as a large gap.
    assign dt        = i_now - r_last;
    assign rep_over  = dt > i_repeat;
    assign win_below = dt < i_window;
    assign win_over  = dt > i_window;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            bcdr_pkg::PH_IDLE: begin
                if (i_pressed) n_phase = bcdr_pkg::PH_DOWN1;
            end
            bcdr_pkg::PH_DOWN1: begin
                if (!i_pressed) n_phase = bcdr_pkg::PH_UP1;
                else if (rep_over) n_phase = bcdr_pkg::PH_HELD;
            end
            bcdr_pkg::PH_UP1: begin
                if (i_pressed && win_below) n_phase = bcdr_pkg::PH_DOWN2;
                else if (!i_pressed && win_over) n_phase = bcdr_pkg::PH_IDLE;
            end
            bcdr_pkg::PH_DOWN2: begin
                if (!i_pressed && (win_below || win_over)) n_phase = bcdr_pkg::PH_IDLE;
            end
            bcdr_pkg::PH_HELD: begin
                if (!i_pressed) n_phase = bcdr_pkg::PH_IDLE;
            end
            default: n_phase = r_phase;
        endcase
    end

    always_comb begin
        record    = 1'b0;
        o_evt.dbl = 1'b0;
        unique case (r_phase)
            bcdr_pkg::PH_IDLE:  record = i_pressed;
            bcdr_pkg::PH_DOWN1: record = i_pressed && rep_over;
            bcdr_pkg::PH_HELD:  record = i_pressed && rep_over;
            bcdr_pkg::PH_DOWN2: o_evt.dbl = !i_pressed && win_below;
            default: begin
                record    = 1'b0;
                o_evt.dbl = 1'b0;
            end
        endcase
        o_evt.click = record;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bcdr_pkg::PH_IDLE;
        end else if (i_en) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && record) begin
            r_last <= i_now;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bcdr_merge.sv
// Merging stage: gathers lane events into the two masks and holds the result.
`default_nettype none
module bcdr_merge (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_accept,
    input  wire bcdr_pkg::t_lane_evt [bcdr_pkg::NUM_BUTTONS-1:0] i_evt,
    input  wire                                         i_m_tready,
    output logic                                        o_s_tready,
    output logic                                        o_m_tvalid,
    output logic [2*bcdr_pkg::NUM_BUTTONS-1:0]          o_m_tdata
);

    logic [bcdr_pkg::NUM_BUTTONS-1:0] clk_mask;
    logic [bcdr_pkg::NUM_BUTTONS-1:0] dbl_mask;
    logic r_valid;
    logic [2*bcdr_pkg::NUM_BUTTONS-1:0] r_data;

    always_comb begin
        for (int i = 0; i < bcdr_pkg::NUM_BUTTONS; i++) begin
            clk_mask[i] = i_evt[i].click;
            dbl_mask[i] = i_evt[i].dbl;
        end
    end

    // A new item may enter when no result is held or the held result leaves in the same cycle.
    assign o_s_tready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_data <= {dbl_mask, clk_mask};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule
`default_nettype wire

// File: hw/rtl/button_click_double_click_repeat_unit.sv
// Top level of the button click, double click and auto-repeat detector.
//
//  channel  | direction | handshake                  | payload
//  s_*      | in        | s_tvalid / s_tready        | pressed mask, time in us
//  m_*      | out       | m_tvalid / m_tready        | click mask, double click mask
//  APB      | in        | psel, penable, pwrite      | repeat interval, window
//
// All 32 button lanes update in parallel from each accepted item and the
// result enters the output register at the same edge.
// The next item is taken in the following cycle unless a held result is
// stalled by m_tready. Synchronous active-low reset puts every button into
// idle and loads the default interval and window.
`default_nettype none
module button_click_double_click_repeat_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] pressed_mask, [63:32] time_now_us
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [31:0] clicked_mask, [63:32] double_clicked_mask
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_repeat;
    logic [31:0] r_window;
    logic        reg_idx;
    logic        cfg_wr;
    logic        accept;
    logic [bcdr_pkg::NUM_BUTTONS-1:0] pressed;
    logic [bcdr_pkg::TIME_W-1:0] now;
    bcdr_pkg::t_lane_evt [bcdr_pkg::NUM_BUTTONS-1:0] evt;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= bcdr_pkg::REPEAT_RESET;
            r_window <= bcdr_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bcdr_pkg::REG_REPEAT: r_repeat <= pwdata;
                bcdr_pkg::REG_WINDOW: r_window <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bcdr_pkg::REG_REPEAT: prdata = r_repeat;
            bcdr_pkg::REG_WINDOW: prdata = r_window;
            default:              prdata = r_repeat;
        endcase
    end

    assign accept  = s_tvalid && s_tready;
    assign pressed = s_tdata[bcdr_pkg::NUM_BUTTONS-1:0];
    assign now     = s_tdata[63:32];

    for (genvar g = 0; g < bcdr_pkg::NUM_BUTTONS; g++) begin : g_lane
        bcdr_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (accept),
            .i_pressed (pressed[g]),
            .i_now     (now),
            .i_repeat  (r_repeat),
            .i_window  (r_window),
            .o_evt     (evt[g])
        );
    end

    bcdr_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_evt      (evt),
        .i_m_tready (m_tready),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // A button cannot report a click and a double click in the same item.
    a_click_dbl_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[31:0] & m_tdata[63:32]) == 32'd0))
        else $error("click and double click on the same button");

    // The input side is open exactly when the output register can take a result.
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register");

    // No result is shown straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // An accepted item always produces a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");
`endif

endmodule
`default_nettype wire

// File: verif/click_scoreboard.sv
// Scoreboard class that predicts and checks the click and double-click masks.
`timescale 1ns / 100ps
package click_scoreboard_pkg;
    import bcdr_pkg::*;

    class click_scoreboard;
        t_phase      phase[NUM_BUTTONS];
        logic [31:0] last_action_us[NUM_BUTTONS];
        logic [31:0] repeat_us;
        logic [31:0] window_us;
        logic [63:0] expected_masks[$];
        int          mismatches;
        int          errors;

        function new();
            repeat_us  = REPEAT_RESET;
            window_us  = WINDOW_RESET;
            mismatches = 0;
            errors     = 0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                phase[i]          = PH_IDLE;
                last_action_us[i] = '0;
            end
        endfunction

        function void set_reg(input logic idx, input logic [31:0] value);
            if (idx == REG_REPEAT) begin
                repeat_us = value;
            end else begin
                window_us = value;
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        // Advances every button's machine by one accepted item.
        function void note_item(input logic [31:0] mask, input logic [31:0] now_us);
            logic [31:0] clicks;
            logic [31:0] doubles;
            logic [31:0] dt;
            t_phase      ph;
            clicks  = '0;
            doubles = '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                ph = phase[i];
                dt = now_us - last_action_us[i];
                if (mask[i]) begin
                    if (ph == PH_IDLE) begin
                        ph                = PH_DOWN1;
                        last_action_us[i] = now_us;
                        clicks[i]         = 1'b1;
                    end else if ((ph == PH_DOWN1 || ph == PH_HELD) && dt > repeat_us) begin
                        ph                = PH_HELD;
                        last_action_us[i] = now_us;
                        clicks[i]         = 1'b1;
                    end else if (ph == PH_UP1 && dt < window_us) begin
                        ph = PH_DOWN2;
                    end
                end else begin
                    if (ph == PH_DOWN1) begin
                        ph = PH_UP1;
                    end else if (ph == PH_DOWN2 && dt < window_us) begin
                        ph         = PH_IDLE;
                        doubles[i] = 1'b1;
                    end else if (ph == PH_DOWN2 && dt > window_us) begin
                        ph = PH_IDLE;
                    end else if (ph == PH_UP1 && dt > window_us) begin
                        ph = PH_IDLE;
                    end else if (ph == PH_HELD) begin
                        ph = PH_IDLE;
                    end
                end
                phase[i] = ph;
            end
            expected_masks.push_back({doubles, clicks});
        endfunction

        function void check_result(input logic [63:0] got);
            logic [63:0] want;
            if (expected_masks.size() == 0) begin
                errors++;
                if (mismatches < 10) begin
                    $display("unexpected result: clicked %h double %h",
                             got[31:0], got[63:32]);
                end
                mismatches++;
                return;
            end
            want = expected_masks.pop_front();
            if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32]) begin
                errors++;
                if (mismatches < 10) begin
                    $display("mismatch: clicked exp %h got %h, double exp %h got %h",
                             want[31:0], got[31:0], want[63:32], got[63:32]);
                end
                mismatches++;
            end
        endfunction
    endclass
endpackage

// File: verif/tb_top.sv
// Top-level testbench for the button click, double-click and auto-repeat unit.
`timescale 1ns / 100ps
module tb_top;
    import bcdr_pkg::*;
    import click_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 105;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] pressed_mask, [63:32] time_now_us
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] clicked_mask, [63:32] double_clicked_mask
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    click_scoreboard sb;
    bit              gaps_on;
    bit              hold_req;
    int              hold_left;
    int              cycles;
    logic [31:0]     mask_now;
    logic [31:0]     now_us;

    button_click_double_click_repeat_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    task automatic send_item(input logic [31:0] mask, input logic [31:0] t_us);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t_us, mask};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        sb.note_item(mask, t_us);
    endtask

    // Stops offering items until every expected result has come back.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly slow edits of the mask with small time steps, now and then noise.
    task automatic send_random(input int scale);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            mask_now = $urandom;
            now_us   = $urandom;
        end else begin
            mask_now = mask_now ^ ($urandom & $urandom & $urandom);
            case ($urandom_range(0, 9))
                0: now_us = now_us;
                1: now_us = now_us + 1;
                default: now_us = now_us + $urandom_range(0, 2 * scale);
            endcase
        end
        send_item(mask_now, now_us);
    endtask

    initial begin
        logic [31:0] rep_cfg[NUM_PHASES];
        logic [31:0] win_cfg[NUM_PHASES];
        int          scale[NUM_PHASES];
        sb       = new();
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        cycles   = 0;
        mask_now = '0;
        now_us   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset interval and window.
        send_item(32'h0000_0000, 32'd0);
        send_item(32'h0000_0001, 32'd1000);
        send_item(32'h0000_0000, 32'd2000);
        // A press exactly one window after the first press keeps the phase.
        send_item(32'h0000_0001, 32'd301000);
        send_item(32'h0000_0001, 32'd300999);
        // A release exactly at the window boundary also keeps the phase.
        send_item(32'h0000_0000, 32'd301000);
        send_item(32'h0000_0000, 32'd300500);
        send_item(32'hFFFF_FFFF, 32'd1000000);
        send_item(32'hFFFF_FFFF, 32'd1500000);
        send_item(32'hFFFF_FFFF, 32'd1500001);
        send_item(32'hFFFF_0000, 32'd1600000);
        send_item(32'h0000_0000, 32'hFFFF_FFFF);
        // Presses just before the counter wraps, then times just after it.
        send_item(32'h8000_0001, 32'hFFFF_FFF0);
        send_item(32'h8000_0001, 32'h0000_0010);
        send_item(32'h0000_0000, 32'h0000_0020);
        send_item(32'h8000_0001, 32'h0000_0030);
        send_item(32'h0000_0000, 32'h0FFF_FFFF);
        send_item(32'h0000_0001, 32'd5);
        send_item(32'h0000_0000, 32'd6);
        send_item(32'h0000_0000, 32'd300006);
        send_item(32'h5555_AAAA, 32'h8000_0000);
        send_item(32'h0000_0000, 32'h8000_0001);

        rep_cfg = '{REPEAT_RESET, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd37, 32'd0};
        win_cfg = '{WINDOW_RESET, 32'hFFFF_FFFF, 32'd0, 32'd60, 32'd200, 32'd0};
        scale   = '{400000, 1000, 1000, 100, 150, 3000};
        rep_cfg[5] = $urandom_range(1, 5000);
        win_cfg[5] = $urandom_range(1, 5000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            apb_write(REG_REPEAT, rep_cfg[p]);
            apb_write(REG_WINDOW, win_cfg[p]);
            gaps_on = (p != 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 30) begin
                    hold_req = 1'b1;
                end
                if (p == 2 && k == 50) begin
                    drain();
                end
                send_random(scale[p]);
            end
        end
        gaps_on = 1'b1;

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: button_click_double_click_repeat_unit.f
hw/rtl/bcdr_pkg.sv
hw/rtl/bcdr_lane.sv
hw/rtl/bcdr_merge.sv
hw/rtl/button_click_double_click_repeat_unit.sv
verif/click_scoreboard.sv
verif/tb_top.sv
